[rtl/wstat_pkg.sv]
// Package for the sliding-window statistics block.
// Holds register indexes, fixed field widths and the controller/datapath structs.
// No dependencies.
package wstat_pkg;

  // Fixed widths of the configuration and count fields.
  localparam int WINLEN_BITS   = 9;
  localparam int CNT_OUT_BITS  = 9;
  localparam int EXT_DIVISOR   = 100;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WINDOW_LEN  = 2'd0;
  localparam logic [1:0] REG_PCT_ENABLE  = 2'd1;
  localparam logic [1:0] REG_PCT_HIGH    = 2'd2;

  // Current configuration values.
  typedef struct packed {
    logic [WINLEN_BITS-1:0] window_len;
    logic                   pct_enable;
    logic                   pct_high;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;
    logic walk;
    logic esum;
    logic div_start;
    logic div_sel;
    logic lat_mean;
    logic lat_ext;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic esum_done;
    logic div_busy;
    logic out_busy;
  } stat_t;

endpackage

[rtl/wstat_if.sv]
// Valid/ready channel interfaces for the statistics block.
// Depends on nothing; values are SAMPLE_BITS wide, valid_total 9 bits.
interface wstat_in_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   want_metrics;
  modport source (output valid, output sample, output want_metrics, input ready);
  modport sink (input valid, input sample, input want_metrics, output ready);
endinterface

interface wstat_out_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] min_value;
  logic [SAMPLE_BITS-1:0] max_value;
  logic [SAMPLE_BITS-1:0] mean_value;
  logic [SAMPLE_BITS-1:0] extreme_mean;
  logic [8:0]             valid_total;
  modport source (output valid, output min_value, output max_value, output mean_value,
                  output extreme_mean, output valid_total, input ready);
  modport sink (input valid, input min_value, input max_value, input mean_value,
                input extreme_mean, input valid_total, output ready);
endinterface

[rtl/wstat_div.sv]
// Restoring divider, one quotient bit per cycle.
// Used by the datapath for both means; no package dependency.
module wstat_div #(
  parameter int NW = 25,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);
  localparam int KW = $clog2(NW + 1);

  logic [NW-1:0] dvd_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dsr_r;
  logic [KW-1:0] step_r;
  logic          busy_r;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  // One trial subtraction per cycle.
  assign rem_sh = {rem_r, dvd_r[NW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};
  assign diff   = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == KW'(NW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Shift register holds the dividend, then the quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;
endmodule

[rtl/wstat_dp.sv]
// Datapath: sample ring memory, window walk, extreme list, mean divisions, output register.
// Depends on wstat_pkg and wstat_div.
module wstat_dp
  import wstat_pkg::*;
#(
  parameter int WINDOW_DEPTH = 256,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    win_wr,
  input  logic [WINLEN_BITS-1:0]  win_data,
  input  logic                    in_accept,
  input  logic [SAMPLE_BITS-1:0]  in_sample,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [SAMPLE_BITS-1:0]  out_min,
  output logic [SAMPLE_BITS-1:0]  out_max,
  output logic [SAMPLE_BITS-1:0]  out_mean,
  output logic [SAMPLE_BITS-1:0]  out_ext,
  output logic [CNT_OUT_BITS-1:0] out_total
);
  localparam int AW      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW      = $clog2(WINDOW_DEPTH + 1);
  localparam int SW      = SAMPLE_BITS + CW;
  localparam int LW      = (CW > WINLEN_BITS) ? CW : WINLEN_BITS;
  localparam int MAX_EXT = WINDOW_DEPTH / EXT_DIVISOR + 1;
  localparam int EW      = $clog2(MAX_EXT + 1);
  localparam int VW      = CW + CNT_OUT_BITS;

  logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic [AW-1:0]          wslot_r;
  logic [CW-1:0]          vcount_r;
  logic [AW-1:0]          rd_ptr_r;
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          issued_r;
  logic                   rdv_r;
  logic [SAMPLE_BITS-1:0] mn_r;
  logic [SAMPLE_BITS-1:0] mx_r;
  logic [SW-1:0]          sum_r;
  logic [6:0]             c100_r;
  logic [CW-1:0]          q100_r;
  logic [SAMPLE_BITS-1:0] list_r [MAX_EXT];
  logic [SAMPLE_BITS-1:0] list_nxt [MAX_EXT];
  logic [EW-1:0]          e_idx_r;
  logic [SW-1:0]          esum_r;
  logic [SAMPLE_BITS-1:0] mean_r;
  logic [SAMPLE_BITS-1:0] ext_r;
  logic                   out_valid_r;
  logic [CW-1:0]          eff_len;
  logic [CW-1:0]          eff_new;
  logic [CW-1:0]          n_ext;
  logic                   issue;
  logic [SAMPLE_BITS-1:0] sentinel;
  logic [SW-1:0]          div_dvd;
  logic [CW-1:0]          div_dsr;
  logic [SW-1:0]          div_q;
  logic                   div_busy;
  logic                   none;
  logic [VW-1:0]          cnt_wide;

  // Window length clipped to the memory depth.
  function automatic logic [CW-1:0] eff_of(input logic [WINLEN_BITS-1:0] len);
    logic [LW-1:0] wl;
    wl = LW'(len);
    eff_of = (wl > LW'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH) : CW'(wl);
  endfunction

  assign eff_len  = eff_of(cfg.window_len);
  assign eff_new  = eff_of(win_data);
  assign n_ext    = q100_r + 1'b1;
  assign issue    = cmd.walk && (issued_r != cnt_r);
  assign sentinel = cfg.pct_high ? '0 : '1;

  // Sample memory: one write per accepted item, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem[wslot_r] <= in_sample;
    end
    rd_data_r <= mem[rd_ptr_r];
  end

  // Write slot and count of valid newest samples. Valid slots are always
  // the newest ones, so a count replaces per-slot marks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r  <= '0;
      vcount_r <= '0;
    end else if (in_accept) begin
      wslot_r  <= (wslot_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wslot_r + 1'b1;
      if (vcount_r != CW'(WINDOW_DEPTH)) begin
        vcount_r <= vcount_r + 1'b1;
      end
    end else if (win_wr && (vcount_r > eff_new)) begin
      vcount_r <= eff_new;
    end
  end

  // Sorted insertion into the extreme list, best entry first.
  always_comb begin
    for (int j = 0; j < MAX_EXT; j++) begin
      logic b_here;
      logic b_prev;
      int   p;
      p = (j == 0) ? 0 : j - 1;
      b_here = cfg.pct_high ? (rd_data_r > list_r[j]) : (rd_data_r < list_r[j]);
      if (j == 0) begin
        b_prev = 1'b0;
      end else begin
        b_prev = cfg.pct_high ? (rd_data_r > list_r[p]) : (rd_data_r < list_r[p]);
      end
      if (!b_here) begin
        list_nxt[j] = list_r[j];
      end else if (b_prev) begin
        list_nxt[j] = list_r[p];
      end else begin
        list_nxt[j] = rd_data_r;
      end
    end
  end

  // Read-valid flag of the walk pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
    end else if (cmd.init) begin
      rdv_r <= 1'b0;
    end else begin
      rdv_r <= issue;
    end
  end

  // Walk, statistics accumulation and extreme sum.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cnt_r    <= (vcount_r < eff_len) ? vcount_r : eff_len;
      issued_r <= '0;
      rd_ptr_r <= (wslot_r == '0) ? AW'(WINDOW_DEPTH - 1) : wslot_r - 1'b1;
      mn_r     <= '1;
      mx_r     <= '0;
      sum_r    <= '0;
      c100_r   <= '0;
      q100_r   <= '0;
      e_idx_r  <= '0;
      esum_r   <= '0;
      for (int j = 0; j < MAX_EXT; j++) begin
        list_r[j] <= sentinel;
      end
    end else begin
      if (issue) begin
        issued_r <= issued_r + 1'b1;
        rd_ptr_r <= (rd_ptr_r == '0) ? AW'(WINDOW_DEPTH - 1) : rd_ptr_r - 1'b1;
      end
      if (rdv_r) begin
        if (rd_data_r < mn_r) mn_r <= rd_data_r;
        if (rd_data_r > mx_r) mx_r <= rd_data_r;
        sum_r <= sum_r + SW'(rd_data_r);
        if (c100_r == 7'(EXT_DIVISOR - 1)) begin
          c100_r <= '0;
          q100_r <= q100_r + 1'b1;
        end else begin
          c100_r <= c100_r + 1'b1;
        end
        list_r <= list_nxt;
      end else if (cmd.esum && !stat.esum_done) begin
        esum_r  <= esum_r + SW'(list_r[0]);
        e_idx_r <= e_idx_r + 1'b1;
        for (int j = 0; j < MAX_EXT - 1; j++) begin
          list_r[j] <= list_r[j+1];
        end
        list_r[MAX_EXT-1] <= sentinel;
      end
    end
  end

  // Shared divider for both means.
  assign div_dvd = cmd.div_sel ? esum_r : sum_r;
  assign div_dsr = cmd.div_sel ? n_ext : cnt_r;

  wstat_div #(.NW(SW), .DW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.lat_mean) mean_r <= div_q[SAMPLE_BITS-1:0];
    if (cmd.lat_ext)  ext_r  <= div_q[SAMPLE_BITS-1:0];
  end

  // Output register; an empty window gives all zeros.
  assign none     = (cnt_r == '0);
  assign cnt_wide = VW'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_min   <= none ? '0 : mn_r;
      out_max   <= none ? '0 : mx_r;
      out_mean  <= none ? '0 : mean_r;
      out_ext   <= (none || !cfg.pct_enable) ? '0 : ext_r;
      out_total <= cnt_wide[CNT_OUT_BITS-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign stat.walk_done = (issued_r == cnt_r) && !rdv_r;
  assign stat.esum_done = (CW'(e_idx_r) == n_ext);
  assign stat.div_busy  = div_busy;
  assign stat.out_busy  = out_valid_r && !out_ready;

`ifndef SYNTH
  // The valid count never exceeds the memory depth.
  a_vcount_range: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= CW'(WINDOW_DEPTH))
    else $error("valid count beyond depth");

  // The walk never issues more reads than the window holds.
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> issued_r <= cnt_r)
    else $error("walk issued too many reads");

  // A divider start is followed by a busy divider.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> div_busy)
    else $error("divider did not start");
`endif
endmodule

[rtl/wstat_ctrl.sv]
// Controller state machine sequencing store, walk, extreme sum, divisions and output.
// Depends on wstat_pkg.
module wstat_ctrl
  import wstat_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_want,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_WALK, S_ESUM, S_MEAN_GO, S_MEAN_WAIT, S_EXT_GO, S_EXT_WAIT,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_valid && in_want) state_nxt = S_INIT;
      S_INIT:      state_nxt = S_WALK;
      S_WALK:      if (stat.walk_done) state_nxt = S_ESUM;
      S_ESUM:      if (stat.esum_done) state_nxt = S_MEAN_GO;
      S_MEAN_GO:   state_nxt = S_MEAN_WAIT;
      S_MEAN_WAIT: if (!stat.div_busy) state_nxt = S_EXT_GO;
      S_EXT_GO:    state_nxt = S_EXT_WAIT;
      S_EXT_WAIT:  if (!stat.div_busy) state_nxt = S_OUT;
      S_OUT:       if (!stat.out_busy) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands decoded from the state.
  always_comb begin
    cmd           = '0;
    cmd.init      = (state_r == S_INIT);
    cmd.walk      = (state_r == S_WALK);
    cmd.esum      = (state_r == S_ESUM);
    cmd.div_start = (state_r == S_MEAN_GO) || (state_r == S_EXT_GO);
    cmd.div_sel   = (state_r == S_EXT_GO) || (state_r == S_EXT_WAIT);
    cmd.lat_mean  = (state_r == S_MEAN_WAIT) && !stat.div_busy;
    cmd.lat_ext   = (state_r == S_EXT_WAIT) && !stat.div_busy;
    cmd.load_out  = (state_r == S_OUT) && !stat.out_busy;
  end

  assign in_ready = (state_r == S_IDLE);
endmodule

[rtl/window_min_max_mean_low_percentile_top.sv]
// Top level of the sliding-window statistics block.
// Depends on wstat_pkg, wstat_if, wstat_ctrl and wstat_dp.
//
// Usage: every input transaction on in_ch stores one sample into a ring of
// WINDOW_DEPTH entries. A transaction with want_metrics set produces one
// transaction on out_ch with the min, max, floor mean, floor mean of the
// cnt/100+1 extreme samples and the valid count over the newest window_len
// samples; other transactions produce nothing.
// A store-only item leaves the controller idle. A metrics item walks the
// sample memory one read per cycle, sums the extreme list, then runs the
// bit-serial divider once for each mean.
// in_ch accepts a new item only when the controller is idle; a finished
// result waits in the output register, and if the receiver stalls the
// next result is held until that register frees up.
// Reset clears the write slot, the valid count and the registers to
// window_len 256, percentile off, low side. Configuration is written over
// the APB port (0x0 window_len, 0x4 percentile_enable, 0x8 percentile_high)
// while idle; the user must keep to this, as the block does not enforce it.
module window_min_max_mean_low_percentile_top
  import wstat_pkg::*;
#(
  parameter int WINDOW_DEPTH = 256,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  wstat_in_if.sink                 in_ch,
  wstat_out_if.source              out_ch,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);
  logic [WINLEN_BITS-1:0] wlen_r;
  logic                   pen_r;
  logic                   phigh_r;
  logic                   wr;
  logic [1:0]             idx;
  logic                   win_wr;
  cfg_t                   cfg;
  cmd_t                   cmd;
  stat_t                  stat;
  logic                   in_ready;
  logic                   in_accept;

  // Register file on the APB port.
  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[3:2];
  assign win_wr     = wr && (idx == REG_WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= WINLEN_BITS'(256);
      pen_r   <= 1'b0;
      phigh_r <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_WINDOW_LEN: wlen_r  <= cfg_pwdata[WINLEN_BITS-1:0];
        REG_PCT_ENABLE: pen_r   <= cfg_pwdata[0];
        REG_PCT_HIGH:   phigh_r <= cfg_pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WINDOW_LEN: cfg_prdata = CFG_DATA_BITS'(wlen_r);
      REG_PCT_ENABLE: cfg_prdata = CFG_DATA_BITS'(pen_r);
      REG_PCT_HIGH:   cfg_prdata = CFG_DATA_BITS'(phigh_r);
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg.window_len = wlen_r;
  assign cfg.pct_enable = pen_r;
  assign cfg.pct_high   = phigh_r;

  // Input handshake.
  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;

  wstat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_want  (in_ch.want_metrics),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wstat_dp #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .win_wr    (win_wr),
    .win_data  (cfg_pwdata[WINLEN_BITS-1:0]),
    .in_accept (in_accept),
    .in_sample (in_ch.sample),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_min   (out_ch.min_value),
    .out_max   (out_ch.max_value),
    .out_mean  (out_ch.mean_value),
    .out_ext   (out_ch.extreme_mean),
    .out_total (out_ch.valid_total)
  );
endmodule
